FILE: design/tmp_pkg.sv
`timescale 1ns / 1ps
// Package for the trapezoidal motion profile block: widths, register indexes,
// action codes and the command type of the shared arithmetic unit. No dependencies.
package tmp_pkg;

   localparam int POS_W      = 32;
   localparam int REG_W      = 31;
   localparam int TIME_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int OPND_W     = 64;
   localparam int RES_W      = 96;
   localparam int MAG_W      = 56;

   localparam logic [CSR_IDX_W-1:0] REG_MAX_VELOCITY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ACCELERATION = 2'd1;
   localparam logic [REG_W-1:0]     REG_RESET_VALUE  = 31'd65536;

   localparam logic ACT_TICK = 1'b0;
   localparam logic ACT_PLAN = 1'b1;

   typedef enum logic [1:0] {
      OP_MUL  = 2'd0,
      OP_DIV  = 2'd1,
      OP_SQRT = 2'd2
   } unit_op_type;

   typedef struct packed {
      logic              start;
      unit_op_type       op;
      logic [OPND_W-1:0] opa;
      logic [OPND_W-1:0] opb;
   } unit_cmd_type;

   typedef struct packed {
      logic             done;
      logic [RES_W-1:0] result;
   } unit_rsp_type;

   function automatic logic [TIME_W-1:0] sat32(input logic [OPND_W-1:0] x);
      logic [TIME_W-1:0] r;
      if (x[OPND_W-1:TIME_W] != '0) r = '1;
      else r = x[TIME_W-1:0];
      return r;
   endfunction

endpackage

FILE: design/tmp_unit.sv
`timescale 1ns / 1ps
// Shared radix-2 arithmetic unit: shift-add multiply, restoring divide and
// digit-by-digit square root, one bit per cycle. Depends on tmp_pkg.
module tmp_unit (
   input  logic                clock,
   input  logic                reset,
   input  tmp_pkg::unit_cmd_type cmd,
   output tmp_pkg::unit_rsp_type rsp
);
   import tmp_pkg::*;

   unit_op_type      op_ff, op_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic [RES_W-1:0] a_ff, a_in;
   logic [OPND_W-1:0] b_ff, b_in;
   logic [RES_W-1:0] acc_ff, acc_in;

   always_comb begin
      logic [32:0] r33;
      logic [34:0] r35;
      logic [34:0] t35;
      op_in   = op_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      r33     = {acc_ff[31:0], b_ff[OPND_W-1]};
      r35     = {acc_ff[32:0], b_ff[OPND_W-1:OPND_W-2]};
      t35     = {1'b0, a_ff[31:0], 2'b01};
      if (cmd.start) begin
         op_in   = cmd.op;
         busy_in = 1'b1;
         acc_in  = '0;
         unique case (cmd.op)
            OP_MUL: begin
               a_in   = {32'b0, cmd.opa};
               b_in   = {32'b0, cmd.opb[31:0]};
               cnt_in = 6'd31;
            end
            OP_DIV: begin
               a_in   = {64'b0, cmd.opb[31:0]};
               b_in   = cmd.opa;
               cnt_in = 6'd63;
            end
            default: begin
               a_in   = '0;
               b_in   = cmd.opa;
               cnt_in = 6'd31;
            end
         endcase
      end else if (busy_ff) begin
         unique case (op_ff)
            OP_MUL: begin
               if (b_ff[0]) acc_in = acc_ff + a_ff;
               a_in = {a_ff[RES_W-2:0], 1'b0};
               b_in = {1'b0, b_ff[OPND_W-1:1]};
            end
            OP_DIV: begin
               if (r33 >= {1'b0, a_ff[31:0]}) begin
                  acc_in = {63'b0, r33 - {1'b0, a_ff[31:0]}};
                  b_in   = {b_ff[OPND_W-2:0], 1'b1};
               end else begin
                  acc_in = {63'b0, r33};
                  b_in   = {b_ff[OPND_W-2:0], 1'b0};
               end
            end
            default: begin
               if (r35 >= t35) begin
                  acc_in = {61'b0, r35 - t35};
                  a_in   = {64'b0, a_ff[30:0], 1'b1};
               end else begin
                  acc_in = {61'b0, r35};
                  a_in   = {64'b0, a_ff[30:0], 1'b0};
               end
               b_in = {b_ff[OPND_W-3:0], 2'b00};
            end
         endcase
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= OP_MUL;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         op_ff   <= op_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   always_comb begin
      rsp.done = done_ff;
      case (op_ff)
         OP_MUL:  rsp.result = acc_ff;
         OP_DIV:  rsp.result = {32'b0, b_ff};
         default: rsp.result = {64'b0, a_ff[31:0]};
      endcase
   end

endmodule

FILE: design/trapezoidal_motion_profile_top.sv
`timescale 1ns / 1ps
// Trapezoidal motion profile generator, top level. Depends on tmp_pkg, tmp_unit.
// A plan request runs two products, a root and a divide for a triangular move, or two
// products and two divides otherwise. A moving tick runs two products on the unit, three
// in the cruise phase; an idle tick and the tick that ends a move run none.
// One request at a time. Synchronous reset restores register defaults.
module trapezoidal_motion_profile_top #(
   parameter int TICK_STEP = 1049
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic signed [tmp_pkg::POS_W-1:0]    req_start_position,
   input  logic signed [tmp_pkg::POS_W-1:0]    req_target_position,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [tmp_pkg::POS_W-1:0]    rsp_setpoint,
   output logic                                rsp_done_res,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tmp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tmp_pkg::REG_W-1:0]           csr_data
);
   import tmp_pkg::*;

   localparam logic [TIME_W:0] STEP33 = (TIME_W+1)'(TICK_STEP);

   typedef enum logic [12:0] {
      ST_IDLE    = 13'b0000000000001,
      ST_P_DA    = 13'b0000000000010,
      ST_P_VV    = 13'b0000000000100,
      ST_P_SQRT  = 13'b0000000001000,
      ST_P_RAMP  = 13'b0000000010000,
      ST_P_COAST = 13'b0000000100000,
      ST_P_TOTAL = 13'b0000001000000,
      ST_T_PHASE = 13'b0000010000000,
      ST_T_SQ    = 13'b0000100000000,
      ST_T_AY    = 13'b0001000000000,
      ST_T_PK    = 13'b0010000000000,
      ST_T_SUM   = 13'b0100000000000,
      ST_RESP    = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic [REG_W-1:0] vmax_ff, vmax_in, accel_ff, accel_in;
   logic [REG_W-1:0] vlat_ff, vlat_in, alat_ff, alat_in;
   logic signed [POS_W-1:0] begin_ff, begin_in, end_ff, end_in;
   logic dirneg_ff, dirneg_in, tri_ff, tri_in, moving_ff, moving_in;
   logic cruise_ff, cruise_in, useend_ff, useend_in, neg_ff, neg_in;
   logic [POS_W-1:0] dist_ff, dist_in;
   logic [OPND_W-1:0] da_ff, da_in, quot_ff, quot_in;
   logic [TIME_W-1:0] peak_ff, peak_in, ramp_ff, ramp_in, coast_ff, coast_in;
   logic [TIME_W-1:0] move_ff, move_in, elapsed_ff, elapsed_in;
   logic [MAG_W-1:0] mag_ff, mag_in;
   logic signed [POS_W-1:0] sp_ff, sp_in;
   logic fin_ff, fin_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_done_ff, rsp_done_in;
   logic signed [POS_W-1:0] rsp_sp_ff, rsp_sp_in;
   unit_cmd_type cmd;
   unit_rsp_type ursp;

   tmp_unit u_unit (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .rsp   (ursp)
   );

   assign req_ready    = (state_ff == ST_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_setpoint = rsp_sp_ff;
   assign rsp_done_res = rsp_done_ff;

   always_comb begin
      logic [POS_W:0]    diff;
      logic [POS_W:0]    dabs;
      logic [REG_W-1:0]  veff, aeff;
      logic [TIME_W:0]   esum, t2;
      logic [TIME_W+1:0] tot;
      logic [TIME_W-1:0] e;
      logic signed [POS_W-1:0] base;
      logic signed [MAG_W+1:0] p;
      state_in   = state_ff;
      vmax_in    = vmax_ff;
      accel_in   = accel_ff;
      vlat_in    = vlat_ff;
      alat_in    = alat_ff;
      begin_in   = begin_ff;
      end_in     = end_ff;
      dirneg_in  = dirneg_ff;
      tri_in     = tri_ff;
      moving_in  = moving_ff;
      cruise_in  = cruise_ff;
      useend_in  = useend_ff;
      neg_in     = neg_ff;
      dist_in    = dist_ff;
      da_in      = da_ff;
      quot_in    = quot_ff;
      peak_in    = peak_ff;
      ramp_in    = ramp_ff;
      coast_in   = coast_ff;
      move_in    = move_ff;
      elapsed_in = elapsed_ff;
      mag_in     = mag_ff;
      sp_in      = sp_ff;
      fin_in     = fin_ff;
      rsp_sp_in  = rsp_sp_ff;
      rsp_done_in = rsp_done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.start  = 1'b0;
      cmd.op     = OP_MUL;
      cmd.opa    = '0;
      cmd.opb    = '0;
      diff = {req_target_position[POS_W-1], req_target_position}
           - {req_start_position[POS_W-1], req_start_position};
      dabs = diff[POS_W] ? -diff : diff;
      veff = (vmax_ff == '0) ? REG_W'(1) : vmax_ff;
      aeff = (accel_ff == '0) ? REG_W'(1) : accel_ff;
      esum = {1'b0, elapsed_ff} + STEP33;
      t2   = {1'b0, ramp_ff} + {1'b0, coast_ff};
      tot  = {1'b0, ramp_ff, 1'b0} + {2'b0, coast_ff};
      e    = elapsed_ff;
      base = useend_ff ? end_ff : begin_ff;
      if (neg_ff) p = {{(MAG_W+2-POS_W){base[POS_W-1]}}, base} - {2'b0, mag_ff};
      else        p = {{(MAG_W+2-POS_W){base[POS_W-1]}}, base} + {2'b0, mag_ff};

      if (csr_valid) begin
         unique case (csr_index)
            REG_MAX_VELOCITY: vmax_in = csr_data;
            REG_ACCELERATION: accel_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_action == ACT_PLAN) begin
                  begin_in   = req_start_position;
                  end_in     = req_target_position;
                  dirneg_in  = diff[POS_W];
                  dist_in    = dabs[POS_W-1:0];
                  vlat_in    = veff;
                  alat_in    = aeff;
                  elapsed_in = '0;
                  cmd.start  = 1'b1;
                  cmd.op     = OP_MUL;
                  cmd.opa    = {32'b0, dabs[POS_W-1:0]};
                  cmd.opb    = {33'b0, aeff};
                  state_in   = ST_P_DA;
               end else if (!moving_ff) begin
                  sp_in    = end_ff;
                  fin_in   = 1'b1;
                  state_in = ST_RESP;
               end else begin
                  elapsed_in = esum[TIME_W] ? '1 : esum[TIME_W-1:0];
                  state_in   = ST_T_PHASE;
               end
            end
         end
         ST_P_DA: begin
            if (ursp.done) begin
               da_in     = ursp.result[OPND_W-1:0];
               cmd.start = 1'b1;
               cmd.op    = OP_MUL;
               cmd.opa   = {33'b0, vlat_ff};
               cmd.opb   = {33'b0, vlat_ff};
               state_in  = ST_P_VV;
            end
         end
         ST_P_VV: begin
            if (ursp.done) begin
               cmd.start = 1'b1;
               if (da_ff <= ursp.result[OPND_W-1:0]) begin
                  tri_in   = 1'b1;
                  cmd.op   = OP_SQRT;
                  cmd.opa  = da_ff;
                  state_in = ST_P_SQRT;
               end else begin
                  tri_in   = 1'b0;
                  peak_in  = {1'b0, vlat_ff};
                  cmd.op   = OP_DIV;
                  cmd.opa  = {13'b0, vlat_ff, 20'b0};
                  cmd.opb  = {33'b0, alat_ff};
                  state_in = ST_P_RAMP;
               end
            end
         end
         ST_P_SQRT: begin
            if (ursp.done) begin
               peak_in   = ursp.result[31:0];
               cmd.start = 1'b1;
               cmd.op    = OP_DIV;
               cmd.opa   = {12'b0, ursp.result[31:0], 20'b0};
               cmd.opb   = {33'b0, alat_ff};
               state_in  = ST_P_RAMP;
            end
         end
         ST_P_RAMP: begin
            if (ursp.done) begin
               quot_in = ursp.result[OPND_W-1:0];
               ramp_in = sat32(ursp.result[OPND_W-1:0]);
               if (tri_ff) begin
                  coast_in = '0;
                  state_in = ST_P_TOTAL;
               end else begin
                  cmd.start = 1'b1;
                  cmd.op    = OP_DIV;
                  cmd.opa   = {12'b0, dist_ff, 20'b0};
                  cmd.opb   = {33'b0, vlat_ff};
                  state_in  = ST_P_COAST;
               end
            end
         end
         ST_P_COAST: begin
            if (ursp.done) begin
               coast_in = sat32(ursp.result[OPND_W-1:0] - quot_ff);
               state_in = ST_P_TOTAL;
            end
         end
         ST_P_TOTAL: begin
            move_in   = (tot[TIME_W+1:TIME_W] != 2'b00) ? '1 : tot[TIME_W-1:0];
            moving_in = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_T_PHASE: begin
            cmd.op  = OP_MUL;
            if ({1'b0, e} <= {1'b0, ramp_ff}) begin
               cruise_in = 1'b0;
               useend_in = 1'b0;
               neg_in    = dirneg_ff;
               cmd.start = 1'b1;
               cmd.opa   = {32'b0, e};
               cmd.opb   = {32'b0, e};
               state_in  = ST_T_SQ;
            end else if ({1'b0, e} <= t2) begin
               cruise_in = 1'b1;
               useend_in = 1'b0;
               neg_in    = dirneg_ff;
               cmd.start = 1'b1;
               cmd.opa   = {32'b0, ramp_ff};
               cmd.opb   = {32'b0, ramp_ff};
               state_in  = ST_T_SQ;
            end else if (e <= move_ff) begin
               cruise_in = 1'b0;
               useend_in = 1'b1;
               neg_in    = !dirneg_ff;
               cmd.start = 1'b1;
               cmd.opa   = {32'b0, move_ff - e};
               cmd.opb   = {32'b0, move_ff - e};
               state_in  = ST_T_SQ;
            end else begin
               moving_in = 1'b0;
               sp_in     = end_ff;
               fin_in    = 1'b1;
               state_in  = ST_RESP;
            end
         end
         ST_T_SQ: begin
            if (ursp.done) begin
               cmd.start = 1'b1;
               cmd.op    = OP_MUL;
               cmd.opa   = ursp.result[OPND_W-1:0];
               cmd.opb   = {33'b0, alat_ff};
               state_in  = ST_T_AY;
            end
         end
         ST_T_AY: begin
            if (ursp.done) begin
               mag_in = {1'b0, ursp.result[RES_W-1:41]};
               if (cruise_ff) begin
                  cmd.start = 1'b1;
                  cmd.op    = OP_MUL;
                  cmd.opa   = {32'b0, peak_ff};
                  cmd.opb   = {32'b0, elapsed_ff - ramp_ff};
                  state_in  = ST_T_PK;
               end else begin
                  state_in = ST_T_SUM;
               end
            end
         end
         ST_T_PK: begin
            if (ursp.done) begin
               mag_in   = mag_ff + {12'b0, ursp.result[63:20]};
               state_in = ST_T_SUM;
            end
         end
         ST_T_SUM: begin
            if (p[MAG_W+1:POS_W-1] == '0 || p[MAG_W+1:POS_W-1] == '1) begin
               sp_in = p[POS_W-1:0];
            end else if (p[MAG_W+1]) begin
               sp_in = {1'b1, {(POS_W-1){1'b0}}};
            end else begin
               sp_in = {1'b0, {(POS_W-1){1'b1}}};
            end
            fin_in   = 1'b0;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_sp_in    = sp_ff;
               rsp_done_in  = fin_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vmax_ff      <= REG_RESET_VALUE;
         accel_ff     <= REG_RESET_VALUE;
         begin_ff     <= '0;
         end_ff       <= '0;
         dirneg_ff    <= 1'b0;
         alat_ff      <= '0;
         peak_ff      <= '0;
         ramp_ff      <= '0;
         coast_ff     <= '0;
         move_ff      <= '0;
         elapsed_ff   <= '0;
         moving_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vmax_ff      <= vmax_in;
         accel_ff     <= accel_in;
         begin_ff     <= begin_in;
         end_ff       <= end_in;
         dirneg_ff    <= dirneg_in;
         alat_ff      <= alat_in;
         peak_ff      <= peak_in;
         ramp_ff      <= ramp_in;
         coast_ff     <= coast_in;
         move_ff      <= move_in;
         elapsed_ff   <= elapsed_in;
         moving_ff    <= moving_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      vlat_ff     <= vlat_in;
      tri_ff      <= tri_in;
      cruise_ff   <= cruise_in;
      useend_ff   <= useend_in;
      neg_ff      <= neg_in;
      dist_ff     <= dist_in;
      da_ff       <= da_in;
      quot_ff     <= quot_in;
      mag_ff      <= mag_in;
      sp_ff       <= sp_in;
      fin_ff      <= fin_in;
      rsp_sp_ff   <= rsp_sp_in;
      rsp_done_ff <= rsp_done_in;
   end

endmodule
